// ----- rtl/avgp_pkg.sv -----
// Shared types and constants for the 4x4 stride-4 average pooling block.
`default_nettype none
package avgp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int GROUPS     = MAX_WIDTH / 4;

    localparam int SAMPLE_W = 16;
    localparam int RUN_W    = SAMPLE_W + 2;   // four samples
    localparam int SUM_W    = SAMPLE_W + 4;   // sixteen samples
    localparam int GRP_W    = $clog2(GROUPS);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int OROW_W   = ROW_W - 2;
    localparam int PLANE_W  = 16;

    localparam int RW_W = 11;
    localparam int FH_W = 13;
    localparam int PC_W = 16;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int TDATA_W  = 40;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        REG_ROW_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PLANE_COUNT  = 2'd2
    } t_reg_idx;

    // One classified pixel, handed from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       grp_first;
        logic                       grp_last;
        logic                       band_first;
        logic                       band_last;
        logic [GRP_W-1:0]           grp;
        logic [OROW_W-1:0]          orow;
        logic                       eop;
        logic                       eob;
    } t_item;

endpackage
`default_nettype wire

// ----- rtl/avg_pool_4x4_stride4.sv -----
// Top level: 4x4 stride-4 average pooling over a pixel stream, APB config.
// Throughput: one pixel transaction per clock, sustained while results are taken.
// A block result reaches the output through the queue, the group-close stage and the result register.
// The band sum memory has one read and one write port, each used once per group.
// Reset (i_rst_n, synchronous, active low) clears the position counters, queue and
// result valid; registers return to width 64, height 64, one plane. No clearing pass.
`default_nettype none
module avg_pool_4x4_stride4 (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input stream
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire  [avgp_pkg::SAMPLE_W-1:0]      i_s_axis_tdata,  // [15:0] sample
    // result stream
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    output logic [avgp_pkg::TDATA_W-1:0]       o_m_axis_tdata,  // [15:0] average,
                                                                // [25:16] out_row,
                                                                // [33:26] out_col, rest 0
    output logic                               o_m_axis_tlast,  // end_of_plane
    output logic                               o_m_axis_tuser,  // [0] end_of_batch
    // configuration
    input  wire                                i_psel,
    input  wire                                i_penable,
    input  wire                                i_pwrite,
    input  wire  [avgp_pkg::PADDR_W-1:0]       i_paddr,
    input  wire  [avgp_pkg::PDATA_W-1:0]       i_pwdata,
    output logic [avgp_pkg::PDATA_W-1:0]       o_prdata,
    output logic                               o_pready
);

    // configuration registers
    logic [avgp_pkg::RW_W-1:0] r_row_width;
    logic [avgp_pkg::FH_W-1:0] r_frame_height;
    logic [avgp_pkg::PC_W-1:0] r_plane_count;
    logic                      cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite & o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= avgp_pkg::RW_W'(64);
            r_frame_height <= avgp_pkg::FH_W'(64);
            r_plane_count  <= avgp_pkg::PC_W'(1);
        end else if (cfg_wr) begin
            case (avgp_pkg::t_reg_idx'(i_paddr[3:2]))
                avgp_pkg::REG_ROW_WIDTH:    r_row_width    <= i_pwdata[avgp_pkg::RW_W-1:0];
                avgp_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_pwdata[avgp_pkg::FH_W-1:0];
                avgp_pkg::REG_PLANE_COUNT:  r_plane_count  <= i_pwdata[avgp_pkg::PC_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (avgp_pkg::t_reg_idx'(i_paddr[3:2]))
            avgp_pkg::REG_ROW_WIDTH:    o_prdata = avgp_pkg::PDATA_W'(r_row_width);
            avgp_pkg::REG_FRAME_HEIGHT: o_prdata = avgp_pkg::PDATA_W'(r_frame_height);
            avgp_pkg::REG_PLANE_COUNT:  o_prdata = avgp_pkg::PDATA_W'(r_plane_count);
            default:                    o_prdata = '0;
        endcase
    end

    // front: counters and classification, pushes one transaction per pixel
    logic             q_full, q_valid, q_pop, push;
    avgp_pkg::t_item  f_item, q_item;

    assign o_s_axis_tready = !q_full;

    avgp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .i_ready        (o_s_axis_tready),
        .i_sample       (i_s_axis_tdata),
        .i_row_width    (r_row_width),
        .i_frame_height (r_frame_height),
        .i_plane_count  (r_plane_count),
        .o_push         (push),
        .o_item         (f_item)
    );

    // decoupling queue, lets the input keep flowing during short output stalls
    avgp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    // back: sums, band memory and result register
    logic signed [avgp_pkg::SAMPLE_W-1:0] avg;
    logic [avgp_pkg::OROW_W-1:0]          orow;
    logic [avgp_pkg::GRP_W-1:0]           ocol;

    avgp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_average (avg),
        .o_out_row (orow),
        .o_out_col (ocol),
        .o_eop     (o_m_axis_tlast),
        .o_eob     (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = avgp_pkg::TDATA_W'({ocol, orow, avg});

endmodule
`default_nettype wire

// ----- rtl/avgp_front.sv -----
// Front end: position counters and per-pixel classification.
`default_nettype none
module avgp_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    input  wire                              i_ready,
    input  wire  [avgp_pkg::SAMPLE_W-1:0]    i_sample,
    input  wire  [avgp_pkg::RW_W-1:0]        i_row_width,
    input  wire  [avgp_pkg::FH_W-1:0]        i_frame_height,
    input  wire  [avgp_pkg::PC_W-1:0]        i_plane_count,
    output logic                             o_push,
    output avgp_pkg::t_item                  o_item
);

    logic [avgp_pkg::COL_W-1:0]   r_col,   n_col;
    logic [avgp_pkg::ROW_W-1:0]   r_row,   n_row;
    logic [avgp_pkg::PLANE_W-1:0] r_plane, n_plane;

    logic [avgp_pkg::RW_W-1:0]    w_floor, w_eff, w_m1;
    logic [avgp_pkg::FH_W-1:0]    h_floor, h_eff, h_m1;
    logic [avgp_pkg::PC_W-1:0]    pc_m1;
    logic                         last_col, last_row, last_plane;

    always_comb begin
        w_floor = {i_row_width[avgp_pkg::RW_W-1:2], 2'b00};
        if (w_floor < avgp_pkg::RW_W'(4)) begin
            w_eff = avgp_pkg::RW_W'(4);
        end else if (w_floor > avgp_pkg::RW_W'(avgp_pkg::MAX_WIDTH)) begin
            w_eff = avgp_pkg::RW_W'(avgp_pkg::MAX_WIDTH);
        end else begin
            w_eff = w_floor;
        end
        w_m1 = w_eff - avgp_pkg::RW_W'(1);

        h_floor = {i_frame_height[avgp_pkg::FH_W-1:2], 2'b00};
        if (h_floor < avgp_pkg::FH_W'(4)) begin
            h_eff = avgp_pkg::FH_W'(4);
        end else if (h_floor > avgp_pkg::FH_W'(avgp_pkg::MAX_HEIGHT)) begin
            h_eff = avgp_pkg::FH_W'(avgp_pkg::MAX_HEIGHT);
        end else begin
            h_eff = h_floor;
        end
        h_m1 = h_eff - avgp_pkg::FH_W'(1);

        // zero planes counts as one
        pc_m1 = (i_plane_count == '0) ? '0 : i_plane_count - avgp_pkg::PC_W'(1);

        last_col   = avgp_pkg::RW_W'(r_col) >= w_m1;
        last_row   = avgp_pkg::FH_W'(r_row) >= h_m1;
        last_plane = r_plane >= pc_m1;
    end

    assign o_push = i_valid & i_ready;

    always_comb begin
        o_item.sample     = i_sample;
        o_item.grp_first  = (r_col[1:0] == 2'b00);
        o_item.grp_last   = (r_col[1:0] == 2'b11);
        o_item.band_first = (r_row[1:0] == 2'b00);
        o_item.band_last  = (r_row[1:0] == 2'b11);
        o_item.grp        = r_col[avgp_pkg::COL_W-1:2];
        o_item.orow       = r_row[avgp_pkg::ROW_W-1:2];
        o_item.eop        = last_col & last_row;
        o_item.eob        = last_col & last_row & last_plane;
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_plane = r_plane;
        if (o_push) begin
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row   = '0;
                    n_plane = last_plane ? '0 : r_plane + avgp_pkg::PLANE_W'(1);
                end else begin
                    n_row = r_row + avgp_pkg::ROW_W'(1);
                end
            end else begin
                n_col = r_col + avgp_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
        end
    end

    // closing pixel of a plane must bring both counters back to the origin
    a_eop_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.eop) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after end of plane");

endmodule
`default_nettype wire

// ----- rtl/avgp_queue.sv -----
// Small FIFO of classified pixels between front and back.
`default_nettype none
module avgp_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  avgp_pkg::t_item       i_item,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire                   i_pop,
    output avgp_pkg::t_item       o_item
);

    avgp_pkg::t_item                r_mem [avgp_pkg::QDEPTH];
    logic [avgp_pkg::QPTR_W-1:0]    r_wr, r_rd;
    logic [avgp_pkg::QCNT_W-1:0]    r_count, n_count;

    assign o_full  = (r_count == avgp_pkg::QCNT_W'(avgp_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + avgp_pkg::QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - avgp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + avgp_pkg::QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + avgp_pkg::QPTR_W'(1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- rtl/avgp_back.sv -----
// Back end: row run sums, band sum memory read-modify-write, result register.
`default_nettype none
module avgp_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_q_valid,
    input  avgp_pkg::t_item                    i_q_item,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic signed [avgp_pkg::SAMPLE_W-1:0] o_average,
    output logic [avgp_pkg::OROW_W-1:0]        o_out_row,
    output logic [avgp_pkg::GRP_W-1:0]         o_out_col,
    output logic                               o_eop,
    output logic                               o_eob
);

    logic                                 en;
    logic signed [avgp_pkg::RUN_W-1:0]    r_run, n_run, s_ext;
    logic signed [avgp_pkg::SUM_W-1:0]    r_rd, n_sum;
    logic signed [avgp_pkg::SUM_W-1:0]    gs_mem [avgp_pkg::GROUPS];

    // group-close stage
    logic                                 r_b_valid;
    logic signed [avgp_pkg::RUN_W-1:0]    r_b_run;
    logic                                 r_b_band_first, r_b_band_last;
    logic [avgp_pkg::GRP_W-1:0]           r_b_grp;
    logic [avgp_pkg::OROW_W-1:0]          r_b_orow;
    logic                                 r_b_eop, r_b_eob;

    // everything advances together when the result slot can take a value
    assign en      = !o_valid || i_ready;
    assign o_q_pop = en && i_q_valid;

    always_comb begin
        s_ext = avgp_pkg::RUN_W'(i_q_item.sample);
        n_run = i_q_item.grp_first ? s_ext : r_run + s_ext;
        n_sum = r_b_band_first ? avgp_pkg::SUM_W'(r_b_run)
                               : r_rd + avgp_pkg::SUM_W'(r_b_run);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            o_valid   <= 1'b0;
            r_run     <= '0;
        end else if (en) begin
            r_b_valid <= o_q_pop && i_q_item.grp_last;
            o_valid   <= r_b_valid && r_b_band_last;
            if (o_q_pop) r_run <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b_run        <= n_run;
            r_b_band_first <= i_q_item.band_first;
            r_b_band_last  <= i_q_item.band_last;
            r_b_grp        <= i_q_item.grp;
            r_b_orow       <= i_q_item.orow;
            r_b_eop        <= i_q_item.eop;
            r_b_eob        <= i_q_item.eob;
        end
        if (en && r_b_valid && r_b_band_last) begin
            o_average <= n_sum[avgp_pkg::SUM_W-1:4];
            o_out_row <= r_b_orow;
            o_out_col <= r_b_grp;
            o_eop     <= r_b_eop;
            o_eob     <= r_b_eob;
        end
    end

    // band sum memory: read when a group closes, written one stage later
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.grp_last) r_rd <= gs_mem[i_q_item.grp];
        if (en && r_b_valid) gs_mem[r_b_grp] <= n_sum;
    end

    a_eob_has_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_eob) |-> o_eop)
        else $error("end of batch without end of plane");

    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !en) |=> (r_b_valid && $stable(r_b_grp)))
        else $error("group-close stage lost its transaction while stalled");

endmodule
`default_nettype wire
